// ===== sv/ucb1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb1_pkg
// Shared constants, controller commands and status for the UCB1 arm selector.
// ----------------------------------------------------------------------------
package ucb1_pkg;

  localparam int MAX_ARMS = 16;
  localparam int IDX_W    = 4;
  localparam int ARMS_W   = 5;
  localparam int GAIN_W   = 24;
  localparam int COUNT_W  = 32;
  localparam int TOTAL_W  = 36;
  localparam int MEAN_W   = 32;
  localparam int KEY_W    = 34;
  localparam int DIV_W    = 33;
  localparam int LN_W     = 22;
  localparam int SQ_W     = 38;
  localparam int ROOT_W   = 19;
  localparam int RND_W    = 16;
  localparam int K_W      = 5;
  localparam int E_W      = 6;
  localparam int FRAC_W   = 16;
  localparam int M_W      = 31;
  localparam int CFG_W    = 24;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Configuration register indexes.
  localparam logic CFG_ARMS = 1'b0;
  localparam logic CFG_GAIN = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_UPD_DIV,
    CMD_UPD_WR,
    CMD_CKEY,
    CMD_PK_MAX,
    CMD_PK_CNT,
    CMD_PK_J,
    CMD_PK_SEL,
    CMD_SET_MOST,
    CMD_LN_START,
    CMD_RATIO,
    CMD_SQRT,
    CMD_SCORE,
    CMD_OUT
  } cmd_e;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_NORM,
    LN_SQ,
    LN_MUL
  } ln_ph_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UPD,
    ST_UPD_WAIT,
    ST_UPD_WR,
    ST_CKEY,
    ST_MAX,
    ST_CNT,
    ST_J,
    ST_SEL,
    ST_MOST,
    ST_BRANCH,
    ST_LN_WAIT,
    ST_RATIO,
    ST_RATIO_WAIT,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_SCORE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic upd;
    logic eor;
    logic zfound;
    logic last;
    logic div_busy;
    logic ln_busy;
    logic sqrt_busy;
  } status_t;

endpackage

// ===== sv/ucb1_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb1_dp
// Datapath: arm statistics, shared divider, log and root units, tie picker.
// ----------------------------------------------------------------------------
module ucb1_dp import ucb1_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_e                cmd_i,
  output status_t             st_o,
  input  logic                mode_i,
  input  logic [MEAN_W-1:0]   reward_i,
  input  logic [RND_W-1:0]    rnd_i,
  input  logic                eor_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  output logic [IDX_W-1:0]    next_arm_o,
  output logic [IDX_W-1:0]    most_arm_o,
  output logic                run_done_o
);

  logic [ARMS_W-1:0]         arms_q;
  logic [GAIN_W-1:0]         gain_q;
  logic                      mode_q, eor_q;
  logic signed [MEAN_W-1:0]  reward_q;
  logic [RND_W-1:0]          rnd_q;
  logic [IDX_W-1:0]          pend_arm_q;
  logic                      pend_val_q;
  logic signed [MEAN_W-1:0]  mean_q [MAX_ARMS];
  logic [COUNT_W-1:0]        cnt_q  [MAX_ARMS];
  logic signed [KEY_W-1:0]   key_q  [MAX_ARMS];
  logic [TOTAL_W-1:0]        total_q;
  logic [IDX_W-1:0]          idx_q, n_m1;
  logic                      zf_q;
  logic [IDX_W-1:0]          zidx_q;
  logic signed [KEY_W-1:0]   best_q;
  logic [K_W-1:0]            k_q, j_q;
  logic                      picked_q;
  logic [IDX_W-1:0]          pick_q, most_q;
  logic [IDX_W-1:0]          next_q, mostout_q;
  logic                      run_q;

  // Divider
  logic [DIV_W:0]            div_rem_q;
  logic [DIV_W-1:0]          div_quo_q, div_den_q;
  logic [5:0]                div_cnt_q;
  logic                      div_busy_q, div_neg_q;

  // Log unit
  ln_ph_e                    ln_ph_q;
  logic [TOTAL_W-1:0]        norm_q;
  logic [E_W-1:0]            e_q;
  logic [M_W-1:0]            m_q;
  logic [FRAC_W-1:0]         frac_q;
  logic [3:0]                lcnt_q;
  logic [LN_W-1:0]           ln_q;

  // Root unit
  logic [SQ_W-1:0]           sq_v_q, sq_res_q, sq_bit_q;

  logic signed [MEAN_W-1:0]  cur_mean;
  logic [COUNT_W-1:0]        cur_cnt;
  logic signed [KEY_W-1:0]   cur_key;
  logic signed [KEY_W-1:0]   diff;
  logic [DIV_W-1:0]          diff_abs;
  logic [DIV_W:0]            div_sh;
  logic [DIV_W:0]            q_s;
  logic [2*M_W-1:0]          sq_prod;
  logic [M_W:0]              sq_top;
  logic [LN_W+31:0]          ln_prod;
  logic [SQ_W-1:0]           sq_trial;
  logic [GAIN_W+ROOT_W-1:0]  bonus_prod;
  logic [RND_W+K_W-1:0]      j_prod;
  logic                      key_eq;
  logic                      last;

  always_comb begin
    if (arms_q == '0) begin
      n_m1 = '0;
    end else if (arms_q > ARMS_W'(MAX_ARMS)) begin
      n_m1 = IDX_W'(MAX_ARMS - 1);
    end else begin
      n_m1 = IDX_W'(arms_q - ARMS_W'(1));
    end
  end

  assign last       = (idx_q == n_m1);
  assign cur_mean   = mean_q[idx_q];
  assign cur_cnt    = cnt_q[idx_q];
  assign cur_key    = key_q[idx_q];
  assign key_eq     = (cur_key == best_q);
  assign diff       = KEY_W'(reward_q) - KEY_W'(cur_mean);
  assign diff_abs   = diff[KEY_W-1] ? DIV_W'(-diff) : DIV_W'(diff);
  assign div_sh     = {div_rem_q[DIV_W-1:0], div_quo_q[DIV_W-1]};
  assign q_s        = div_neg_q ? ((DIV_W+1)'(0) - {1'b0, div_quo_q}) : {1'b0, div_quo_q};
  assign sq_prod    = m_q * m_q;
  assign sq_top     = sq_prod[2*M_W-1:30];
  assign ln_prod    = {e_q, frac_q} * LN2_Q32;
  assign sq_trial   = sq_res_q + sq_bit_q;
  assign bonus_prod = gain_q * sq_res_q[ROOT_W-1:0];
  assign j_prod     = (RND_W+K_W)'(rnd_q) * (RND_W+K_W)'(k_q);

  always_comb begin
    st_o.upd       = mode_q && pend_val_q;
    st_o.eor       = eor_q;
    st_o.zfound    = zf_q;
    st_o.last      = last;
    st_o.div_busy  = div_busy_q;
    st_o.ln_busy   = (ln_ph_q != LN_IDLE);
    st_o.sqrt_busy = (sq_bit_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arms_q     <= ARMS_W'(MAX_ARMS);
      gain_q     <= GAIN_W'(65536);
      pend_arm_q <= '0;
      pend_val_q <= 1'b0;
      total_q    <= '0;
      for (int i = 0; i < MAX_ARMS; i++) begin
        mean_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      idx_q      <= '0;
      div_busy_q <= 1'b0;
      ln_ph_q    <= LN_IDLE;
      sq_bit_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ARMS: arms_q <= cfg_data_i[ARMS_W-1:0];
          default:  gain_q <= cfg_data_i[GAIN_W-1:0];
        endcase
      end

      // Shared divider, one quotient bit per cycle.
      if (div_busy_q) begin
        if (div_sh >= {1'b0, div_den_q}) begin
          div_rem_q <= div_sh - {1'b0, div_den_q};
          div_quo_q <= {div_quo_q[DIV_W-2:0], 1'b1};
        end else begin
          div_rem_q <= div_sh;
          div_quo_q <= {div_quo_q[DIV_W-2:0], 1'b0};
        end
        div_cnt_q <= div_cnt_q - 6'd1;
        if (div_cnt_q == 6'd0) begin
          div_busy_q <= 1'b0;
        end
      end

      // Log unit: normalize, then sixteen squaring steps, then scale by ln 2.
      unique case (ln_ph_q)
        LN_NORM: begin
          if (norm_q[TOTAL_W-1]) begin
            m_q     <= norm_q[TOTAL_W-1:TOTAL_W-M_W];
            lcnt_q  <= 4'd15;
            ln_ph_q <= LN_SQ;
          end else begin
            norm_q <= {norm_q[TOTAL_W-2:0], 1'b0};
            e_q    <= e_q - E_W'(1);
          end
        end
        LN_SQ: begin
          if (sq_top[M_W]) begin
            m_q            <= sq_top[M_W:1];
            frac_q[lcnt_q] <= 1'b1;
          end else begin
            m_q <= sq_top[M_W-1:0];
          end
          lcnt_q <= lcnt_q - 4'd1;
          if (lcnt_q == 4'd0) begin
            ln_ph_q <= LN_MUL;
          end
        end
        LN_MUL: begin
          ln_q    <= ln_prod[LN_W+31:32];
          ln_ph_q <= LN_IDLE;
        end
        default: ;
      endcase

      // Root unit, one result bit per cycle.
      if (sq_bit_q != '0) begin
        if (sq_v_q >= sq_trial) begin
          sq_v_q   <= sq_v_q - sq_trial;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end

      unique case (cmd_i)
        CMD_LOAD: begin
          mode_q   <= mode_i;
          reward_q <= reward_i;
          rnd_q    <= rnd_i;
          eor_q    <= eor_i;
          idx_q    <= pend_arm_q;
          zf_q     <= 1'b0;
        end
        CMD_UPD_DIV: begin
          div_rem_q  <= '0;
          div_quo_q  <= diff_abs;
          div_den_q  <= DIV_W'(cur_cnt) + DIV_W'(1);
          div_neg_q  <= diff[KEY_W-1];
          div_cnt_q  <= 6'(DIV_W - 1);
          div_busy_q <= 1'b1;
        end
        CMD_UPD_WR: begin
          // Statistics change only for a reward on a pending arm.
          if (mode_q && pend_val_q) begin
            mean_q[idx_q] <= cur_mean + q_s[MEAN_W-1:0];
            if (cur_cnt != '1) begin
              cnt_q[idx_q] <= cur_cnt + COUNT_W'(1);
            end
            if (total_q != '1) begin
              total_q <= total_q + TOTAL_W'(1);
            end
          end
          idx_q <= '0;
        end
        CMD_CKEY: begin
          key_q[idx_q] <= KEY_W'(cur_cnt);
          if (cur_cnt == '0 && !zf_q) begin
            zf_q   <= 1'b1;
            zidx_q <= idx_q;
          end
          idx_q <= last ? '0 : idx_q + IDX_W'(1);
        end
        CMD_PK_MAX: begin
          if (idx_q == '0 || cur_key > best_q) begin
            best_q <= cur_key;
          end
          idx_q <= last ? '0 : idx_q + IDX_W'(1);
        end
        CMD_PK_CNT: begin
          k_q   <= ((idx_q == '0) ? K_W'(0) : k_q) + K_W'(key_eq);
          idx_q <= last ? '0 : idx_q + IDX_W'(1);
        end
        CMD_PK_J: begin
          j_q      <= j_prod[RND_W+K_W-1:RND_W];
          picked_q <= 1'b0;
        end
        CMD_PK_SEL: begin
          if (key_eq && !picked_q) begin
            if (j_q == '0) begin
              pick_q   <= idx_q;
              picked_q <= 1'b1;
            end else begin
              j_q <= j_q - K_W'(1);
            end
          end
          idx_q <= last ? '0 : idx_q + IDX_W'(1);
        end
        CMD_SET_MOST: most_q <= pick_q;
        CMD_LN_START: begin
          norm_q <= total_q;
          e_q    <= E_W'(TOTAL_W - 1);
          frac_q <= '0;
          if (total_q == '0) begin
            ln_q <= '0;
          end else begin
            ln_ph_q <= LN_NORM;
          end
        end
        CMD_RATIO: begin
          div_rem_q  <= '0;
          div_quo_q  <= DIV_W'(ln_q);
          div_den_q  <= DIV_W'(cur_cnt);
          div_neg_q  <= 1'b0;
          div_cnt_q  <= 6'(DIV_W - 1);
          div_busy_q <= 1'b1;
        end
        CMD_SQRT: begin
          sq_v_q   <= {div_quo_q[LN_W-1:0], 16'd0};
          sq_res_q <= '0;
          sq_bit_q <= SQ_W'(1) << (SQ_W - 2);
        end
        CMD_SCORE: begin
          key_q[idx_q] <= KEY_W'(cur_mean)
                        + KEY_W'(bonus_prod[GAIN_W+ROOT_W-1:16]);
          idx_q <= last ? '0 : idx_q + IDX_W'(1);
        end
        CMD_OUT: begin
          run_q     <= eor_q;
          mostout_q <= most_q;
          if (eor_q) begin
            next_q     <= '0;
            pend_val_q <= 1'b0;
          end else begin
            next_q     <= zf_q ? zidx_q : pick_q;
            pend_arm_q <= zf_q ? zidx_q : pick_q;
            pend_val_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign next_arm_o = next_q;
  assign most_arm_o = mostout_q;
  assign run_done_o = run_q;

endmodule

// ===== sv/ucb1_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb1_ctrl
// Controller: sequences update, scans, log, divides and roots per item.
// ----------------------------------------------------------------------------
module ucb1_ctrl import ucb1_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t st_i,
  output cmd_e    cmd_o
);

  state_e state_q, state_d;
  logic   score_q, score_d;
  logic   ovld_q, ovld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      score_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      score_q <= score_d;
      ovld_q  <= ovld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    score_d    = score_q;
    ovld_d     = ovld_q && !out_ready_i;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          score_d = 1'b0;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (st_i.upd) begin
          cmd_o   = CMD_UPD_DIV;
          state_d = ST_UPD_WAIT;
        end else begin
          state_d = ST_UPD_WR;
        end
      end
      ST_UPD_WAIT: if (!st_i.div_busy) state_d = ST_UPD_WR;
      ST_UPD_WR: begin
        // The datapath skips the update when no reward is pending; the arm
        // index is rewound either way.
        cmd_o   = CMD_UPD_WR;
        state_d = ST_CKEY;
      end
      ST_CKEY: begin
        cmd_o = CMD_CKEY;
        if (st_i.last) state_d = ST_MAX;
      end
      ST_MAX: begin
        cmd_o = CMD_PK_MAX;
        if (st_i.last) state_d = ST_CNT;
      end
      ST_CNT: begin
        cmd_o = CMD_PK_CNT;
        if (st_i.last) state_d = ST_J;
      end
      ST_J: begin
        cmd_o   = CMD_PK_J;
        state_d = ST_SEL;
      end
      ST_SEL: begin
        cmd_o = CMD_PK_SEL;
        if (st_i.last) state_d = score_q ? ST_FIN : ST_MOST;
      end
      ST_MOST: begin
        cmd_o   = CMD_SET_MOST;
        state_d = ST_BRANCH;
      end
      ST_BRANCH: begin
        if (st_i.eor || st_i.zfound) begin
          state_d = ST_FIN;
        end else begin
          cmd_o   = CMD_LN_START;
          state_d = ST_LN_WAIT;
        end
      end
      ST_LN_WAIT: if (!st_i.ln_busy) state_d = ST_RATIO;
      ST_RATIO: begin
        cmd_o   = CMD_RATIO;
        state_d = ST_RATIO_WAIT;
      end
      ST_RATIO_WAIT: if (!st_i.div_busy) state_d = ST_SQRT;
      ST_SQRT: begin
        cmd_o   = CMD_SQRT;
        state_d = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: if (!st_i.sqrt_busy) state_d = ST_SCORE;
      ST_SCORE: begin
        cmd_o = CMD_SCORE;
        if (st_i.last) begin
          score_d = 1'b1;
          state_d = ST_MAX;
        end else begin
          state_d = ST_RATIO;
        end
      end
      ST_FIN: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o   = CMD_OUT;
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ovld_q;

endmodule

// ===== sv/ucb1_arm_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucb1_arm_selector
// UCB1 multi-armed bandit arm selector with a stream interface.
// ----------------------------------------------------------------------------
// Each input item either requests an arm (tuser 0) or reports the reward of
// the arm handed out last (tuser 1). A reward updates that arm's running mean
// through a shift-subtract divider, then the block scans the arms in use to
// find the most-drawn arm and the next arm to draw: the lowest arm never
// drawn, or the arm with the highest UCB1 score (arm 0 at the end of a run).
// One item is worked on at a time. A full scoring pass works out the log
// (normalization plus sixteen squarings) and, for every arm, a division and
// a square root; the arm loop through the shared divider and root unit
// dominates the time an item takes. A finished result waits in an output
// register, and the next item is accepted while it waits. Configuration is
// to be written by the user only while the block is idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module ucb1_arm_selector import ucb1_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input items.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,   // [31:0] reward, [47:32] tie_random
  input  logic                s_axis_tuser,   // [0] mode
  input  logic                s_axis_tlast,   // end_of_run
  // Result items.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [3:0] next_arm, [7:4] most_drawn_arm
  output logic                m_axis_tlast,   // run_done
  // Configuration writes: index 0 arms_in_use, index 1 exploration_gain.
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  cmd_e             cmd;
  status_t          st;
  logic [IDX_W-1:0] next_arm, most_arm;

  ucb1_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  ucb1_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .mode_i     (s_axis_tuser),
    .reward_i   (s_axis_tdata[31:0]),
    .rnd_i      (s_axis_tdata[47:32]),
    .eor_i      (s_axis_tlast),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .next_arm_o (next_arm),
    .most_arm_o (most_arm),
    .run_done_o (m_axis_tlast)
  );

  assign m_axis_tdata = {most_arm, next_arm};

endmodule
